// ----- sv/qxm_pkg.sv -----
// Shared types, command codes, mixing signs and arithmetic helpers for the
// quad-X motor mixer. No dependencies; used by qxm_mix and the top level.
`default_nettype none

package qxm_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int PULSE_W     = 12;
    localparam int CORR_W      = 16;
    localparam int SUM_W       = 17;

    // Command codes carried on the input tuser.
    localparam logic [1:0] CMD_MIX    = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_ARM    = 2'd2;
    localparam logic [1:0] CMD_DISARM = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_MIN_THROTTLE = 1'b0;
    localparam logic REG_MAX_THROTTLE = 1'b1;

    localparam logic [PULSE_W-1:0] MIN_THROTTLE_RST = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_THROTTLE_RST = 12'd2000;
    localparam logic [PULSE_W-1:0] PULSE_RST        = 12'd1000;

    // Negation mask per motor: bit 0 roll, bit 1 pitch, bit 2 yaw.
    // Motor order is front-left, front-right, back-left, back-right.
    localparam logic [2:0] MIX_NEG [MOTOR_COUNT] = '{3'b110, 3'b011, 3'b000, 3'b101};

    // The duty (p*16384 + 10000) / 20000 equals (p*512 + 312) / 625, because the
    // dropped low five bits never carry. The division by 625 is a multiply by
    // ceil(2^31 / 625) and a shift by 31, exact for all 21-bit dividends.
    localparam logic [42:0] DUTY_RECIP  = 43'd3435974;
    localparam logic [20:0] DUTY_OFFSET = 21'd312;

    typedef logic [MOTOR_COUNT-1:0][PULSE_W-1:0] pulse_arr_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [PULSE_W-1:0] throttle;
        logic [CORR_W-1:0]  roll;
        logic [CORR_W-1:0]  pitch;
        logic [CORR_W-1:0]  yaw;
        logic [1:0]         motor_index;
        logic [PULSE_W-1:0] pulse_value;
    } item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] min_throttle;
        logic [PULSE_W-1:0] max_throttle;
    } bounds_t;

    // Quarter of a signed correction, truncated toward zero.
    function automatic logic signed [SUM_W-1:0] quarter(input logic [CORR_W-1:0] c);
        logic signed [SUM_W-1:0] ext;
        ext = $signed({c[CORR_W-1], c});
        if (c[CORR_W-1]) begin
            ext = ext + 17'sd3;
        end
        return ext >>> 2;
    endfunction

    // Clamp to the minimum first, then to the maximum, so the maximum wins.
    function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [SUM_W-1:0] v,
                                                       input bounds_t b);
        logic signed [SUM_W-1:0] r;
        r = v;
        if (r < $signed({5'd0, b.min_throttle})) begin
            r = $signed({5'd0, b.min_throttle});
        end
        if (r > $signed({5'd0, b.max_throttle})) begin
            r = $signed({5'd0, b.max_throttle});
        end
        return r[PULSE_W-1:0];
    endfunction

    function automatic logic [PULSE_W-1:0] duty_of(input logic [PULSE_W-1:0] pulse);
        logic [20:0] y;
        logic [42:0] prod;
        y    = {pulse, 9'd0} + DUTY_OFFSET;
        prod = 43'(y) * DUTY_RECIP;
        return prod[42:31];
    endfunction

endpackage

`default_nettype wire

// ----- sv/qxm_mix.sv -----
// Next-state logic of the mixer: the four motor pulses and the armed flag
// after one command. Depends on qxm_pkg.
`default_nettype none

module qxm_mix (
    input  wire qxm_pkg::item_t      item,
    input  wire qxm_pkg::bounds_t    bounds,
    input  wire qxm_pkg::pulse_arr_t pulse_cur,
    input  wire logic                armed_cur,
    output qxm_pkg::pulse_arr_t      pulse_next,
    output logic                     armed_next
);

    logic signed [qxm_pkg::SUM_W-1:0] q_roll;
    logic signed [qxm_pkg::SUM_W-1:0] q_pitch;
    logic signed [qxm_pkg::SUM_W-1:0] q_yaw;
    logic [qxm_pkg::PULSE_W-1:0]      min_clamped;
    qxm_pkg::pulse_arr_t              mixed;

    assign q_roll      = qxm_pkg::quarter(item.roll);
    assign q_pitch     = qxm_pkg::quarter(item.pitch);
    assign q_yaw       = qxm_pkg::quarter(item.yaw);
    assign min_clamped = qxm_pkg::clamp_pulse($signed({5'd0, bounds.min_throttle}), bounds);

    // Four independent mixers, one per motor.
    always_comb begin
        for (int i = 0; i < qxm_pkg::MOTOR_COUNT; i++) begin
            mixed[i] = qxm_pkg::clamp_pulse(
                $signed({5'd0, item.throttle})
                + (qxm_pkg::MIX_NEG[i][0] ? -q_roll  : q_roll)
                + (qxm_pkg::MIX_NEG[i][1] ? -q_pitch : q_pitch)
                + (qxm_pkg::MIX_NEG[i][2] ? -q_yaw   : q_yaw),
                bounds);
        end
    end

    always_comb begin
        pulse_next = pulse_cur;
        armed_next = armed_cur;
        case (item.command)
            qxm_pkg::CMD_MIX: begin
                // A disarmed mix parks every motor at the stop value.
                pulse_next = armed_cur ? mixed : {qxm_pkg::MOTOR_COUNT{min_clamped}};
            end
            qxm_pkg::CMD_SET: begin
                pulse_next[item.motor_index] =
                    qxm_pkg::clamp_pulse($signed({5'd0, item.pulse_value}), bounds);
            end
            qxm_pkg::CMD_ARM: begin
                armed_next = 1'b1;
            end
            qxm_pkg::CMD_DISARM: begin
                armed_next = 1'b0;
                pulse_next = {qxm_pkg::MOTOR_COUNT{min_clamped}};
            end
            default: begin
                pulse_next = pulse_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/quad_x_motor_mixer_core.sv -----
// Top level of the quad-X motor mixer: stream ports, APB register file,
// motor state and the result register. Depends on qxm_pkg and qxm_mix.
//
//  Port group   Direction  Beat contents
//  s_axis_*     in         one command with its throttle, corrections and set value
//  m_axis_*     out        four stored pulses, four duties and the armed flag
//  APB          in/out     min_throttle at 0x0, max_throttle at 0x4
//
// Each accepted command beat produces exactly one result beat in the next cycle. A
// new command can be accepted in every cycle; the rate is one beat per cycle, set
// by the single result register, which refills in the same cycle its beat is taken.
// When the result is stalled, s_axis_tready drops until the result leaves. Reset
// restores both bounds, parks all motors at 1000 us and disarms. The user must
// write the bounds only while the block is idle; the block does not enforce it.
`default_nettype none

module quad_x_motor_mixer_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, lowest bit first: throttle[11:0], roll[27:12], pitch[43:28],
    // yaw[59:44], motor_index[61:60], pulse_value[73:62], zero pad[79:74]
    input  wire logic [79:0]  s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]   s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, lowest bit first: pulse_front_left[11:0], pulse_front_right[23:12],
    // pulse_back_left[35:24], pulse_back_right[47:36], duty_front_left[59:48],
    // duty_front_right[71:60], duty_back_left[83:72], duty_back_right[95:84],
    // armed_flag[96], zero pad[103:97]
    output logic [103:0]      m_axis_tdata,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int ARMED_BIT = 96;

    qxm_pkg::item_t      item;
    qxm_pkg::bounds_t    bounds_reg;
    qxm_pkg::pulse_arr_t pulse_reg;
    qxm_pkg::pulse_arr_t pulse_next;
    logic                armed_reg;
    logic                armed_next;
    logic                m_valid_reg;
    logic [103:0]        m_data_reg;
    logic [103:0]        m_data_next;
    logic                accept;
    logic                cfg_write;

    // Unpack the command beat.
    assign item.command     = s_axis_tuser;
    assign item.throttle    = s_axis_tdata[11:0];
    assign item.roll        = s_axis_tdata[27:12];
    assign item.pitch       = s_axis_tdata[43:28];
    assign item.yaw         = s_axis_tdata[59:44];
    assign item.motor_index = s_axis_tdata[61:60];
    assign item.pulse_value = s_axis_tdata[73:62];

    // The result register frees itself in the same cycle its beat is taken.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // APB: zero wait states; the register is selected by address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            qxm_pkg::REG_MIN_THROTTLE: prdata = {20'd0, bounds_reg.min_throttle};
            qxm_pkg::REG_MAX_THROTTLE: prdata = {20'd0, bounds_reg.max_throttle};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg.min_throttle <= qxm_pkg::MIN_THROTTLE_RST;
            bounds_reg.max_throttle <= qxm_pkg::MAX_THROTTLE_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                qxm_pkg::REG_MIN_THROTTLE: bounds_reg.min_throttle <= pwdata[11:0];
                qxm_pkg::REG_MAX_THROTTLE: bounds_reg.max_throttle <= pwdata[11:0];
                default:                   bounds_reg <= bounds_reg;
            endcase
        end
    end

    qxm_mix u_mix (
        .item       (item),
        .bounds     (bounds_reg),
        .pulse_cur  (pulse_reg),
        .armed_cur  (armed_reg),
        .pulse_next (pulse_next),
        .armed_next (armed_next)
    );

    // Duties are derived from the pulses being stored, so the result beat
    // always reports the state left behind by its own command.
    always_comb begin
        m_data_next            = '0;
        m_data_next[47:0]      = pulse_next;
        for (int i = 0; i < qxm_pkg::MOTOR_COUNT; i++) begin
            m_data_next[48 + 12*i +: 12] = qxm_pkg::duty_of(pulse_next[i]);
        end
        m_data_next[ARMED_BIT] = armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg   <= {qxm_pkg::MOTOR_COUNT{qxm_pkg::PULSE_RST}};
            armed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                pulse_reg   <= pulse_next;
                armed_reg   <= armed_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // A disarm beat is reported disarmed with the FL, FR and BR pulses equal.
    a_disarm_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_axis_tuser == qxm_pkg::CMD_DISARM |=>
            m_axis_tvalid && !m_axis_tdata[ARMED_BIT]
            && m_axis_tdata[11:0] == m_axis_tdata[23:12]
            && m_axis_tdata[11:0] == m_axis_tdata[47:36])
        else $error("disarm result not parked");

    // A mix while disarmed must not spin any motor differently.
    a_disarmed_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_axis_tuser == qxm_pkg::CMD_MIX && !armed_reg |=>
            m_axis_tdata[11:0] == m_axis_tdata[35:24]
            && m_axis_tdata[23:12] == m_axis_tdata[47:36]
            && m_axis_tdata[11:0] == m_axis_tdata[23:12])
        else $error("disarmed mix moved a motor");

    // The pending result always matches the motor state it was taken from.
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[47:0] == pulse_reg
            && m_axis_tdata[ARMED_BIT] == armed_reg)
        else $error("result beat out of step with motor state");

    // An arm beat leaves the stored pulses untouched.
    a_arm_keeps_pulses: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_axis_tuser == qxm_pkg::CMD_ARM |=> $stable(pulse_reg) && armed_reg)
        else $error("arm changed the motor pulses");
`endif

endmodule

`default_nettype wire

// ----- verif/quad_x_motor_mixer_core_tb.sv -----
// Testbench for quad_x_motor_mixer_core: a directed table of commands, then random command
// streams under several throttle bounds, all results checked against the table or a model.
// Depends on qxm_pkg for command codes and register indexes, and on the mixer core RTL.
module quad_x_motor_mixer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any beat on either stream before the run is declared hung. The
    // longest legal quiet stretch is the deliberate result stall below.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_STALL      = 400;
    localparam int PRESSURE_AT     = 1350;
    localparam int DRAIN_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int N_PHASES        = 9;
    localparam int N_ROWS          = 22;

    // Throttle bounds per random phase; a negative entry draws both bounds at random.
    // The list holds the reset values, the widest and narrowest windows, crossed bounds
    // and both corners of the 12-bit range.
    localparam int PHASE_MIN [N_PHASES] = '{1000, 0, 1500, 3000, 4095, -1, 0, 4095, 1100};
    localparam int PHASE_MAX [N_PHASES] = '{2000, 4095, 1600, 1000, 4095, -1, 0, 0, 1900};

    // Sign of roll, pitch and yaw for each motor of the X frame: FL, FR, BL, BR.
    localparam int MIX_SIGN [qxm_pkg::MOTOR_COUNT][3] = '{'{1, -1, -1}, '{-1, -1, 1},
                                                          '{1, 1, 1}, '{-1, 1, -1}};

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] throttle;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [1:0]  motor_index;
        logic [11:0] pulse_value;
    } mixer_cmd_t;

    // Laid out exactly like m_axis_tdata[96:0]: pulses first, then duties, then the flag.
    typedef struct packed {
        logic                                  armed;
        logic [qxm_pkg::MOTOR_COUNT-1:0][11:0] duty;
        logic [qxm_pkg::MOTOR_COUNT-1:0][11:0] pulse;
    } motor_report_t;

    // One directed command. Where known is set, the result is written out by hand
    // (pulses and flag; duties follow from the pulses), else the model decides.
    typedef struct packed {
        mixer_cmd_t  cmd;
        logic        known;
        logic [11:0] exp_fl;
        logic [11:0] exp_fr;
        logic [11:0] exp_bl;
        logic [11:0] exp_br;
        logic        exp_armed;
    } cmd_row_t;

    // Directed commands, all at the reset bounds of 1000..2000 us.
    cmd_row_t cmd_rows [N_ROWS] = '{
        // A mix while disarmed parks every motor at the minimum, however large the inputs.
        '{'{qxm_pkg::CMD_MIX, 4095, 32767, -32768, 100, 3, 4095}, 1, 1000, 1000, 1000, 1000, 0},
        // Arm only raises the flag; the unused fields carry junk.
        '{'{qxm_pkg::CMD_ARM, 4095, -1, -1, -1, 3, 4095}, 1, 1000, 1000, 1000, 1000, 1},
        '{'{qxm_pkg::CMD_MIX, 1500, 0, 0, 0, 0, 0}, 1, 1500, 1500, 1500, 1500, 1},
        // Full throttle and zero throttle hit the two bounds.
        '{'{qxm_pkg::CMD_MIX, 4095, 0, 0, 0, 0, 0}, 1, 2000, 2000, 2000, 2000, 1},
        '{'{qxm_pkg::CMD_MIX, 0, 0, 0, 0, 0, 0}, 1, 1000, 1000, 1000, 1000, 1},
        // Corrections below four in magnitude truncate to nothing, negative ones included.
        '{'{qxm_pkg::CMD_MIX, 1500, -3, 3, -1, 0, 0}, 1, 1500, 1500, 1500, 1500, 1},
        // Pure roll: the left motors go up, the right ones down.
        '{'{qxm_pkg::CMD_MIX, 1500, 400, 0, 0, 0, 0}, 1, 1600, 1400, 1600, 1400, 1},
        '{'{qxm_pkg::CMD_MIX, 1500, -5, 7, -9, 0, 0}, 0, 0, 0, 0, 0, 0},
        '{'{qxm_pkg::CMD_MIX, 1500, 32767, 32767, 32767, 0, 0}, 0, 0, 0, 0, 0, 0},
        '{'{qxm_pkg::CMD_MIX, 1500, -32768, -32768, -32768, 0, 0}, 0, 0, 0, 0, 0, 0},
        '{'{qxm_pkg::CMD_MIX, 1800, -32768, 12345, -32767, 2, 77}, 0, 0, 0, 0, 0, 0},
        '{'{qxm_pkg::CMD_SET, 0, 0, 0, 0, 3, 4095}, 0, 0, 0, 0, 0, 0},
        // Disarm parks every motor at the minimum and drops the flag.
        '{'{qxm_pkg::CMD_DISARM, 4095, 32767, -32768, 1, 2, 4095}, 1, 1000, 1000, 1000, 1000, 0},
        // Set clamps the requested width and touches only its own motor.
        '{'{qxm_pkg::CMD_SET, 0, 0, 0, 0, 0, 4095}, 1, 2000, 1000, 1000, 1000, 0},
        '{'{qxm_pkg::CMD_SET, 4095, -1, -1, -1, 1, 0}, 1, 2000, 1000, 1000, 1000, 0},
        '{'{qxm_pkg::CMD_SET, 0, 0, 0, 0, 2, 1999}, 1, 2000, 1000, 1999, 1000, 0},
        '{'{qxm_pkg::CMD_SET, 0, 0, 0, 0, 3, 1001}, 1, 2000, 1000, 1999, 1001, 0},
        '{'{qxm_pkg::CMD_ARM, 0, 0, 0, 0, 0, 0}, 1, 2000, 1000, 1999, 1001, 1},
        '{'{qxm_pkg::CMD_ARM, 4095, 32767, 32767, 32767, 3, 4095}, 1, 2000, 1000, 1999, 1001, 1},
        '{'{qxm_pkg::CMD_MIX, 2047, 1, -2, 3, 0, 0}, 1, 2000, 2000, 2000, 2000, 1},
        '{'{qxm_pkg::CMD_DISARM, 0, 0, 0, 0, 0, 0}, 1, 1000, 1000, 1000, 1000, 0},
        '{'{qxm_pkg::CMD_MIX, 1500, 400, 0, 0, 0, 0}, 1, 1000, 1000, 1000, 1000, 0}
    };

    string motor_name [qxm_pkg::MOTOR_COUNT] =
        '{"front-left", "front-right", "back-left", "back-right"};

    // Every input of the block has a known value from time zero.
    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [2:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    // The mixer as the testbench sees it: bounds, stored pulses and the armed flag.
    int           bound_lo = 1000;
    int           bound_hi = 2000;
    logic [11:0]  motor_pulse [qxm_pkg::MOTOR_COUNT] = '{default: 12'd1000};
    logic         motors_armed = 1'b0;

    // Results still owed by the block, oldest first.
    motor_report_t pending_reports [$];

    int n_cmds          = 0;
    int n_reports       = 0;
    int n_mismatch      = 0;
    int n_reg_err       = 0;
    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    int stall_left      = 0;
    bit long_stall_done = 1'b0;
    int quiet_cycles    = 0;

    quad_x_motor_mixer_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 aclk = ~aclk;

    // Minimum first, then maximum, so with crossed bounds the maximum is what sticks.
    function automatic logic [11:0] clamp_to_bounds(input int v);
        if (v < bound_lo) v = bound_lo;
        if (v > bound_hi) v = bound_hi;
        return 12'(v);
    endfunction

    // 14-bit duty count of a pulse width at a 20 ms period, rounded half up by the offset.
    function automatic logic [11:0] duty_count(input logic [11:0] pulse);
        int unsigned d;
        d = (int'(pulse) * 16384 + 10000) / 20000;
        return d[11:0];
    endfunction

    // Applies one command to the model and returns the result beat it should cause.
    function automatic motor_report_t predict_report(input mixer_cmd_t c);
        int            corr [3];
        int            sum;
        motor_report_t rep;
        corr[0] = int'($signed(c.roll));
        corr[1] = int'($signed(c.pitch));
        corr[2] = int'($signed(c.yaw));
        case (c.command)
            qxm_pkg::CMD_MIX: begin
                for (int m = 0; m < qxm_pkg::MOTOR_COUNT; m++) begin
                    sum = int'(c.throttle);
                    // Integer division truncates toward zero, as the quarter must.
                    for (int k = 0; k < 3; k++) sum += (corr[k] * MIX_SIGN[m][k]) / 4;
                    motor_pulse[m] = clamp_to_bounds(motors_armed ? sum : bound_lo);
                end
            end
            qxm_pkg::CMD_SET: begin
                motor_pulse[c.motor_index] = clamp_to_bounds(int'(c.pulse_value));
            end
            qxm_pkg::CMD_ARM: begin
                motors_armed = 1'b1;
            end
            qxm_pkg::CMD_DISARM: begin
                motors_armed = 1'b0;
                for (int m = 0; m < qxm_pkg::MOTOR_COUNT; m++)
                    motor_pulse[m] = clamp_to_bounds(bound_lo);
            end
        endcase
        for (int m = 0; m < qxm_pkg::MOTOR_COUNT; m++) begin
            rep.pulse[m] = motor_pulse[m];
            rep.duty[m]  = duty_count(motor_pulse[m]);
        end
        rep.armed = motors_armed;
        return rep;
    endfunction

    // Mostly widths near the current window so that both clamps and the interior are
    // hit; the rest spans the full 12 bits.
    function automatic logic [11:0] rand_pulse_width();
        int lo;
        int hi;
        lo = (bound_lo < bound_hi ? bound_lo : bound_hi) - 40;
        hi = (bound_lo < bound_hi ? bound_hi : bound_lo) + 40;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        if ($urandom_range(99) < 40) return 12'($urandom);
        return 12'($urandom_range(hi, lo));
    endfunction

    // Corrections: full range, tiny values around the truncation, or moderate ones of
    // at most 2000 in magnitude.
    function automatic logic [15:0] rand_correction();
        case ($urandom_range(9))
            0, 1, 2: return 16'($urandom);
            3:       return 16'(int'($urandom_range(14)) - 7);
            default: return 16'(int'($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Mixes dominate; arm is drawn more often than disarm so most mixes run armed.
    function automatic mixer_cmd_t random_command();
        mixer_cmd_t c;
        int         pick;
        pick          = $urandom_range(99);
        c.command     = pick < 60 ? qxm_pkg::CMD_MIX :
                        pick < 80 ? qxm_pkg::CMD_SET :
                        pick < 92 ? qxm_pkg::CMD_ARM : qxm_pkg::CMD_DISARM;
        c.throttle    = rand_pulse_width();
        c.roll        = rand_correction();
        c.pitch       = rand_correction();
        c.yaw         = rand_correction();
        c.motor_index = 2'($urandom);
        c.pulse_value = rand_pulse_width();
        return c;
    endfunction

    // Offers one command beat, with random gaps ahead of it, and records the result it
    // owes once the beat is taken. Inputs move on the falling edge only.
    task automatic send_command(input mixer_cmd_t c, input bit known,
                                input motor_report_t typed_report);
        motor_report_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, c.pulse_value, c.motor_index, c.yaw, c.pitch, c.roll, c.throttle};
        s_axis_tuser  <= c.command;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        n_cmds++;
        predicted = predict_report(c);
        pending_reports.push_back(known ? typed_report : predicted);
    endtask

    // Stops offering and waits until every owed result has come back, plus a short
    // margin for the result register to settle.
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes one bound over APB (setup then access) and reads it straight back.
    task automatic write_bound(input logic reg_idx, input logic [11:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {20'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_idx == qxm_pkg::REG_MIN_THROTTLE) bound_lo = int'(value);
        else bound_hi = int'(value);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[11:0] !== value) begin
            $display("%0t: bound register at 0x%0h read back: expected %0d, actual %0d",
                     $time, {reg_idx, 2'b00}, value, prdata[11:0]);
            n_reg_err++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side ready. Apart from random stalls, once the command count passes a
    // threshold it holds off for a long stretch so the result register backs up and
    // the block has to drop s_axis_tready while commands keep coming.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!long_stall_done && n_cmds >= PRESSURE_AT) begin
            m_axis_tready   <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Each result beat is compared field by field with the oldest owed result.
    always @(posedge aclk) begin : result_check
        motor_report_t got;
        motor_report_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[96:0];
            n_reports++;
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with no command outstanding: %h", $time, got);
                n_mismatch++;
            end else begin
                want = pending_reports.pop_front();
                for (int m = 0; m < qxm_pkg::MOTOR_COUNT; m++) begin
                    if (got.pulse[m] !== want.pulse[m]) begin
                        $display("%0t: %s pulse: expected %0d, actual %0d",
                                 $time, motor_name[m], want.pulse[m], got.pulse[m]);
                        n_mismatch++;
                    end
                    if (got.duty[m] !== want.duty[m]) begin
                        $display("%0t: %s duty: expected %0d, actual %0d",
                                 $time, motor_name[m], want.duty[m], got.duty[m]);
                        n_mismatch++;
                    end
                end
                if (got.armed !== want.armed) begin
                    $display("%0t: armed flag: expected %0b, actual %0b",
                             $time, want.armed, got.armed);
                    n_mismatch++;
                end
            end
        end
    end

    // Hang detection: any beat on either stream restarts the count.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_reports.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        motor_report_t typed_report;
        int            lo;
        int            hi;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed commands run at the reset bounds with light sender gaps.
        tx_idle_pct = 9;
        rx_idle_pct = 49;
        for (int r = 0; r < N_ROWS; r++) begin
            typed_report.pulse = {cmd_rows[r].exp_br, cmd_rows[r].exp_bl,
                                  cmd_rows[r].exp_fr, cmd_rows[r].exp_fl};
            for (int m = 0; m < qxm_pkg::MOTOR_COUNT; m++)
                typed_report.duty[m] = duty_count(typed_report.pulse[m]);
            typed_report.armed = cmd_rows[r].exp_armed;
            send_command(cmd_rows[r].cmd, cmd_rows[r].known, typed_report);
        end

        // Random phases. Bounds change only once the block has gone quiet; the stored
        // pulses carry over, so duties are always checked against what is held.
        // The first third stalls mostly on the result side, the second mostly on the
        // command side, the last third runs without random idling.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            case (ph / 3)
                0: begin tx_idle_pct = 9;  rx_idle_pct = 49; end
                1: begin tx_idle_pct = 49; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            lo = PHASE_MIN[ph];
            hi = PHASE_MAX[ph];
            if (lo < 0) begin
                lo = $urandom_range(4095);
                hi = $urandom_range(4095);
            end
            write_bound(qxm_pkg::REG_MIN_THROTTLE, 12'(lo));
            write_bound(qxm_pkg::REG_MAX_THROTTLE, 12'(hi));
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_command(random_command(), 1'b0, '0);
        end
        drain_results();

        $display("Checked %0d result beats for %0d commands over %0d bound settings,",
                 n_reports, n_cmds, N_PHASES + 1);
        $display("crossed and extreme bounds included, with one %0d-cycle result stall.",
                 LONG_STALL);
        if (n_mismatch == 0 && n_reg_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
